FILE: design/sfd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the slip frame decoder
package sfd_pkg;

  localparam int unsigned FRAME_CAPACITY_DEFAULT = 255;

  localparam logic [7:0] MARK_END = 8'hC0;
  localparam logic [7:0] MARK_ESC = 8'hDB;
  localparam logic [7:0] ESC_END  = 8'hDC;
  localparam logic [7:0] ESC_ESC  = 8'hDD;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_GOOD  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_length;
    logic       frame_overflow;
  } sfd_res_t;

endpackage

FILE: design/slip_frame_decoder.sv
`timescale 1ns / 1ps
// a byte is held in the input register and its result then in the result register
// throughput: one byte per cycle; while a result is stalled the held byte waits, even one with no result
// the input register advances whenever the result register is empty or being drained
// reset: synchronous, clears both registers' valid flags and returns the decoder to hunting
// no clearing pass after reset; the block is ready in the first cycle out of reset
module slip_frame_decoder import sfd_pkg::*; #(
  parameter int unsigned FRAME_CAPACITY = FRAME_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] payload_byte,
  output logic [7:0] frame_length,
  output logic       frame_overflow
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       free;
  logic       step;
  logic       res_valid;
  sfd_res_t   res;

  // a held byte moves on whenever the result slot can take whatever it yields
  assign step = held_valid && free;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (free),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  sfd_core #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfd_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (step && res_valid),
    .res            (res),
    .free           (free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .frame_length   (frame_length),
    .frame_overflow (frame_overflow)
  );

endmodule

FILE: design/sfd_in_stage.sv
`timescale 1ns / 1ps
// input register holding one received byte until the decoder takes it
module sfd_in_stage import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

FILE: design/sfd_core.sv
`timescale 1ns / 1ps
// deframing state and the per-byte next-state and result logic
module sfd_core import sfd_pkg::*; #(
  parameter int unsigned FRAME_CAPACITY = FRAME_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  output sfd_res_t   res
);

  localparam logic [7:0] CAP_LIMIT =
    (FRAME_CAPACITY > 255) ? 8'd255 : 8'(FRAME_CAPACITY);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_BODY    = 2'd1;
  localparam logic [1:0] PH_ESCAPED = 2'd2;

  logic [1:0] phase, phase_next;
  logic [1:0] header_count, header_count_next;
  logic [7:0] byte_count, byte_count_next;
  logic       overflowed, overflowed_next;
  logic [1:0] hc_inc;

  assign hc_inc = header_count + 2'd1;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    byte_count_next   = byte_count;
    overflowed_next   = overflowed;
    res_valid         = 1'b0;
    res               = '0;
    unique case (phase)
      PH_BODY: begin
        if (byte_in == MARK_ESC) begin
          header_count_next = 2'd0;
          phase_next        = PH_ESCAPED;
        end else if (byte_in == MARK_END) begin
          res_valid = 1'b1;
          if (header_count == 2'd0) begin
            res.kind           = KIND_GOOD;
            res.frame_length   = byte_count;
            res.frame_overflow = overflowed;
          end else begin
            // closing mark right after the header: empty frame
            res.kind = KIND_ABORT;
          end
          phase_next        = PH_HUNT;
          header_count_next = 2'd0;
          byte_count_next   = 8'd0;
          overflowed_next   = 1'b0;
        end else begin
          header_count_next = 2'd0;
          res_valid         = 1'b1;
          res.kind          = KIND_DATA;
          res.payload_byte  = byte_in;
          if (byte_count < CAP_LIMIT) byte_count_next = byte_count + 8'd1;
          else overflowed_next = 1'b1;
        end
      end
      PH_ESCAPED: begin
        header_count_next = 2'd0;
        res_valid         = 1'b1;
        if (byte_in == ESC_END || byte_in == ESC_ESC) begin
          phase_next       = PH_BODY;
          res.kind         = KIND_DATA;
          res.payload_byte = (byte_in == ESC_END) ? MARK_END : MARK_ESC;
          if (byte_count < CAP_LIMIT) byte_count_next = byte_count + 8'd1;
          else overflowed_next = 1'b1;
        end else begin
          res.kind        = KIND_ABORT;
          phase_next      = PH_HUNT;
          byte_count_next = 8'd0;
          overflowed_next = 1'b0;
        end
      end
      default: begin
        // hunting, unused code included
        phase_next = PH_HUNT;
        if (byte_in == MARK_END) begin
          header_count_next = hc_inc;
          if (hc_inc >= 2'd2) begin
            header_count_next = 2'd2;
            byte_count_next   = 8'd0;
            overflowed_next   = 1'b0;
            phase_next        = PH_BODY;
          end
        end else begin
          header_count_next = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      header_count <= 2'd0;
      byte_count   <= 8'd0;
      overflowed   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      byte_count   <= byte_count_next;
      overflowed   <= overflowed_next;
    end
  end

endmodule

FILE: design/sfd_out_stage.sv
`timescale 1ns / 1ps
// result register on the output channel
module sfd_out_stage import sfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  sfd_res_t   res,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] payload_byte,
  output logic [7:0] frame_length,
  output logic       frame_overflow
);

  sfd_res_t held;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign kind           = held.kind;
  assign payload_byte   = held.payload_byte;
  assign frame_length   = held.frame_length;
  assign frame_overflow = held.frame_overflow;

endmodule

FILE: design/sfd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the slip frame decoder, bound to the top level
module sfd_checker import sfd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] payload_byte,
  input logic [7:0] frame_length,
  input logic       frame_overflow
);

  // a stalled transaction holds its result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte)
      && $stable(frame_length) && $stable(frame_overflow))
    else $error("output transaction changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_DATA || kind == KIND_GOOD || kind == KIND_ABORT)
    else $error("undefined result kind");

  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> frame_length == 8'd0 && !frame_overflow)
    else $error("payload result carries frame status");

  a_abort_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ABORT |-> payload_byte == 8'd0 && frame_length == 8'd0
      && !frame_overflow)
    else $error("abort result carries data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .kind           (kind),
  .payload_byte   (payload_byte),
  .frame_length   (frame_length),
  .frame_overflow (frame_overflow)
);

FILE: tb/slip_frame_decoder_tb.sv
`timescale 1ns / 1ps
// testbench for the slip frame decoder: random framed byte streams checked against a predictor
module slip_frame_decoder_tb;
  import sfd_pkg::*;

  typedef enum logic [1:0] {
    HUNTING  = 2'd0,
    IN_FRAME = 2'd1,
    ESCAPED  = 2'd2
  } deframe_phase_t;

  localparam int unsigned CAPACITY =
    (FRAME_CAPACITY_DEFAULT > 255) ? 255 : FRAME_CAPACITY_DEFAULT;
  localparam int CALM_FROM   = 800;
  localparam int CALM_TO     = 1100;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_WAIT  = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [7:0] frame_length;
  logic       frame_overflow;

  logic [7:0] rx_stream[$];
  sfd_res_t   decoded_results[$];
  int         error_count = 0;
  int         stream_items = 0;
  int         cycle_count = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  // predictor state
  deframe_phase_t dec_phase = HUNTING;
  logic [1:0]     header_run = 2'd0;
  logic [7:0]     kept_bytes = 8'd0;
  logic           overflowed = 1'b0;

  slip_frame_decoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .frame_length   (frame_length),
    .frame_overflow (frame_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic bit calm_window();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  task automatic restart_hunt();
    dec_phase  = HUNTING;
    header_run = 2'd0;
    kept_bytes = 8'd0;
    overflowed = 1'b0;
  endtask

  task automatic take_payload(input logic [7:0] b);
    sfd_res_t r;
    r = '0;
    if (kept_bytes < CAPACITY) begin
      kept_bytes = kept_bytes + 8'd1;
    end else begin
      overflowed = 1'b1;
    end
    r.kind = KIND_DATA;
    r.payload_byte = b;
    decoded_results.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    sfd_res_t r;
    r = '0;
    case (dec_phase)
      IN_FRAME: begin
        if (b == MARK_ESC) begin
          header_run = 2'd0;
          dec_phase = ESCAPED;
        end else if (b == MARK_END) begin
          // an end right after the header is an empty frame
          if (header_run == 2'd0) begin
            r.kind = KIND_GOOD;
            r.frame_length = kept_bytes;
            r.frame_overflow = overflowed;
          end else begin
            r.kind = KIND_ABORT;
          end
          decoded_results.push_back(r);
          restart_hunt();
        end else begin
          header_run = 2'd0;
          take_payload(b);
        end
      end
      ESCAPED: begin
        header_run = 2'd0;
        if (b == ESC_END) begin
          dec_phase = IN_FRAME;
          take_payload(MARK_END);
        end else if (b == ESC_ESC) begin
          dec_phase = IN_FRAME;
          take_payload(MARK_ESC);
        end else begin
          r.kind = KIND_ABORT;
          decoded_results.push_back(r);
          restart_hunt();
        end
      end
      default: begin
        dec_phase = HUNTING;
        if (b == MARK_END) begin
          header_run = header_run + 2'd1;
          if (header_run >= 2'd2) begin
            header_run = 2'd2;
            kept_bytes = 8'd0;
            overflowed = 1'b0;
            dec_phase = IN_FRAME;
          end
        end else begin
          header_run = 2'd0;
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < 50) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
    end else if (!in_valid || in_ready) begin
      if (rx_stream.size() > 0 && (calm_window() || $urandom_range(99) >= 22)) begin
        in_valid <= 1'b1;
        rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && cycle_count >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_window() || ($urandom_range(99) >= 22);
    end
  end

  // monitor: predicts on each accepted byte, then checks each accepted result
  always @(posedge clk) begin
    sfd_res_t want;
    if (rst) begin
      restart_hunt();
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(rx_byte);
      end
      if (out_valid && out_ready) begin
        if (decoded_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction kind %0d byte %02h",
                                    kind, payload_byte));
        end else begin
          want = decoded_results.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                      payload_byte, want.payload_byte));
          if (frame_length !== want.frame_length)
            report_mismatch($sformatf("frame_length %0d, expected %0d",
                                      frame_length, want.frame_length));
          if (frame_overflow !== want.frame_overflow)
            report_mismatch($sformatf("frame_overflow %0d, expected %0d",
                                      frame_overflow, want.frame_overflow));
        end
      end
    end
  end

  task automatic send(input logic [7:0] b, input bit counted);
    rx_stream.push_back(b);
    if (counted) stream_items++;
  endtask

  task automatic send_body(input int n);
    int pick;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      b = 8'($urandom_range(255));
      if (pick < 10 || b == MARK_END) begin
        send(MARK_ESC, 1'b1);
        send(ESC_END, 1'b1);
      end else if (pick < 20 || b == MARK_ESC) begin
        send(MARK_ESC, 1'b1);
        send(ESC_ESC, 1'b1);
      end else begin
        send(b, 1'b1);
      end
    end
  endtask

  initial begin
    int frame_no;
    int body_len;
    int pick;
    logic [7:0] bad;

    // noise while hunting, and a lone header byte broken by another byte
    send(8'h00, 1'b1);
    send(8'hFF, 1'b1);
    send(MARK_END, 1'b1);
    send(8'h55, 1'b1);
    // empty frame
    send(MARK_END, 1'b1);
    send(MARK_END, 1'b1);
    send(MARK_END, 1'b1);
    // escapes, one right after the header, and the byte extremes
    send(MARK_END, 1'b1);
    send(MARK_END, 1'b1);
    send(MARK_ESC, 1'b1);
    send(ESC_END, 1'b1);
    send(8'h00, 1'b1);
    send(8'hFF, 1'b1);
    send(MARK_ESC, 1'b1);
    send(ESC_ESC, 1'b1);
    send(MARK_END, 1'b1);
    // bad escape
    send(MARK_END, 1'b1);
    send(MARK_END, 1'b1);
    send(8'h11, 1'b1);
    send(MARK_ESC, 1'b1);
    send(8'h00, 1'b1);
    // bad escape by a frame marker, which must not count toward a header
    send(MARK_END, 1'b1);
    send(MARK_END, 1'b1);
    send(8'h22, 1'b1);
    send(MARK_ESC, 1'b1);
    send(MARK_END, 1'b1);

    frame_no = 0;
    while (stream_items < 740 || frame_no < 10) begin
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 3)) send(8'($urandom_range(255)), 1'b0);
      end
      send(MARK_END, 1'b1);
      send(MARK_END, 1'b1);
      // two long frames: one exactly at capacity, one past it
      pick = $urandom_range(99);
      if (frame_no == 3) body_len = int'(CAPACITY);
      else if (frame_no == 9) body_len = int'(CAPACITY) + 1 + int'($urandom_range(20));
      else if (pick < 8) body_len = 0;
      else if (pick < 85) body_len = $urandom_range(1, 12);
      else body_len = $urandom_range(13, 40);
      send_body(body_len);
      pick = $urandom_range(99);
      if (pick < 82) begin
        send(MARK_END, 1'b1);
      end else if (pick < 92) begin
        bad = 8'($urandom_range(255));
        if (bad == ESC_END || bad == ESC_ESC) bad = MARK_END;
        send(MARK_ESC, 1'b1);
        send(bad, 1'b1);
      end
      // otherwise the frame runs into the next header
      frame_no++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (rx_stream.size() != 0 || in_valid) @(posedge clk);
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout waiting for the decoder to drain");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
